// ===== rtl/bfgl_pkg.sv =====
// Shared types, constants and helpers of the bitmap font glyph layout block.
// No dependencies; every other file of the block imports this package.
package bfgl_pkg;

	localparam int GLYPH_CODES_DEF = 256;
	localparam int FRAC_BITS_DEF   = 8;

	localparam int COORD_W = 24;
	localparam int SUM_W   = COORD_W + 2;
	localparam int KERN_AW = 16;
	localparam int CFG_IW  = 3;

	localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((2 ** (COORD_W - 1)) - 1);
	localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-(2 ** (COORD_W - 1)));

	localparam logic [15:0] FONT_HEIGHT_RST = 16'd4096;
	localparam logic [15:0] SCALE_RST       = 16'd256;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef enum logic [1:0] {
		MODE_GLYPH = 2'd0,
		MODE_KERN  = 2'd1,
		MODE_CHAR  = 2'd2,
		MODE_END   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		KIND_QUAD   = 2'd0,
		KIND_CURSOR = 2'd1,
		KIND_SELECT = 2'd2
	} kind_t;

	typedef enum logic [CFG_IW-1:0] {
		REG_ORIGIN_X     = 3'd0,
		REG_ORIGIN_Y     = 3'd1,
		REG_FONT_HEIGHT  = 3'd2,
		REG_SCALE        = 3'd3,
		REG_CURSOR_INDEX = 3'd4,
		REG_SELECT_BEGIN = 3'd5,
		REG_SELECT_END   = 3'd6,
		REG_CAPTURE_ON   = 3'd7
	} reg_index_t;

	typedef struct packed {
		mode_t             mode;
		logic [7:0]        symbol;
		logic [7:0]        pair_first;
		logic [11:0]       tex_left;
		logic [11:0]       tex_top;
		logic [7:0]        glyph_width;
		logic [7:0]        glyph_height;
		logic signed [7:0] draw_offset_x;
		logic signed [7:0] draw_offset_y;
		logic signed [7:0] amount;
	} item_t;

	typedef struct packed {
		kind_t       kind;
		coord_t      screen_x;
		coord_t      screen_y;
		coord_t      screen_w;
		coord_t      screen_h;
		logic [11:0] src_x;
		logic [11:0] src_y;
		logic [7:0]  src_w;
		logic [7:0]  src_h;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [11:0]       tex_left;
		logic [11:0]       tex_top;
		logic [7:0]        width;
		logic [7:0]        height;
		logic signed [7:0] offset_x;
		logic signed [7:0] offset_y;
		logic signed [7:0] advance;
	} glyph_t;

	// Results of one character, in output order: quad, cursor, selection.
	typedef struct packed {
		logic [2:0]        valid;
		result_t [2:0]     slot;
	} bank_load_t;

	function automatic coord_t sat_coord(input logic signed [SUM_W-1:0] v);
		coord_t r;
		if (v > SAT_HI) begin
			r = SAT_HI[COORD_W-1:0];
		end else if (v < SAT_LO) begin
			r = SAT_LO[COORD_W-1:0];
		end else begin
			r = v[COORD_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== rtl/bfgl_item_if.sv =====
// Input channel of the glyph layout block: valid, ready and one item beat.
// Depends on bfgl_pkg for the item type.
interface bfgl_item_if;
	import bfgl_pkg::*;

	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/bfgl_result_if.sv =====
// Output channel of the glyph layout block: valid, ready and one result beat.
// Depends on bfgl_pkg for the result type.
interface bfgl_result_if;
	import bfgl_pkg::*;

	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/bitmap_font_glyph_layout.sv =====
// Top level of the bitmap font glyph layout block: glyph and kerning memories,
// pen state and result assembly. Depends on bfgl_pkg, both channel interfaces
// and bfgl_result_bank.
//
//   Channel   Role    Beat         Handshake
//   items     sink    item_t       valid / ready
//   results   source  result_t     valid / ready
//   cfg       sink    index, data  write enable, no ready
//
// One item is taken per cycle while the input is not held. Each item is
// registered in the character stage; its results are registered in the output
// bank and leave one beat per cycle while the receiver is ready. The pen
// update (one multiply and a saturating add) is combinational before pen_x_q.
// After reset the kerning memory is cleared, one entry a cycle; no item is
// taken then. A stalled output holds the character stage, and so the input.
module bitmap_font_glyph_layout #(
	parameter int GLYPH_CODES = bfgl_pkg::GLYPH_CODES_DEF,
	parameter int FRAC_BITS   = bfgl_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [bfgl_pkg::CFG_IW-1:0]  cfg_index,
	input  logic [bfgl_pkg::COORD_W-1:0] cfg_wdata,
	bfgl_item_if.sink                    items,
	bfgl_result_if.source                results
);
	import bfgl_pkg::*;

	localparam int GIDX_W = $clog2(GLYPH_CODES);

	// Configuration.
	coord_t      origin_x_q, origin_y_q;
	logic [15:0] font_height_q, scale_q, cursor_index_q, select_begin_q, select_end_q;
	logic        capture_on_q;

	// Layout state.
	coord_t      pen_x_q, sel_left_q;
	logic [15:0] char_idx_q;
	logic [7:0]  prev_sym_q;

	// Memories and clearing pass.
	glyph_t             gmem [GLYPH_CODES];
	logic [7:0]         kmem [2 ** KERN_AW];
	logic [GLYPH_CODES-1:0] gvalid_q;
	logic               clr_busy_q;
	logic [KERN_AW-1:0] clr_addr_q;

	// Character stage.
	logic              valid_s1;
	mode_t             mode_s1;
	logic              gvalid_s1;
	glyph_t            glyph_s1;
	logic signed [7:0] kern_s1;

	logic              accept;
	logic              sym_ok;
	logic [GIDX_W-1:0] gidx;
	logic              s1_go;
	logic              bank_free;
	bank_load_t        load;

	assign sym_ok = {1'b0, items.data.symbol} < 9'(GLYPH_CODES);
	assign gidx   = items.data.symbol[GIDX_W-1:0];
	assign items.ready = !clr_busy_q && (!valid_s1 || s1_go);
	assign accept = items.valid && items.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == {KERN_AW{1'b1}}) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			kmem[clr_addr_q] <= 8'd0;
		end else if (accept && items.data.mode == MODE_KERN) begin
			kmem[{items.data.pair_first, items.data.symbol}] <= items.data.amount;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && items.data.mode == MODE_GLYPH && sym_ok) begin
			gmem[gidx] <= '{
				tex_left: items.data.tex_left,
				tex_top:  items.data.tex_top,
				width:    items.data.glyph_width,
				height:   items.data.glyph_height,
				offset_x: items.data.draw_offset_x,
				offset_y: items.data.draw_offset_y,
				advance:  items.data.amount
			};
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			glyph_s1 <= gmem[gidx];
			kern_s1  <= kmem[{prev_sym_q, items.data.symbol}];
			mode_s1  <= items.data.mode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gvalid_q   <= '0;
			gvalid_s1  <= 1'b0;
			valid_s1   <= 1'b0;
			prev_sym_q <= 8'd0;
		end else begin
			if (accept) begin
				gvalid_s1 <= sym_ok && gvalid_q[gidx];
				if (items.data.mode == MODE_GLYPH && sym_ok) begin
					gvalid_q[gidx] <= 1'b1;
				end
				if (items.data.mode == MODE_CHAR) begin
					prev_sym_q <= items.data.symbol;
				end else if (items.data.mode == MODE_END) begin
					prev_sym_q <= 8'd0;
				end
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// Character stage arithmetic.
	logic                      is_char, is_end, draw, capt;
	logic                      cur_hit, sel_act, sel_mark, sel_emit, res_none;
	logic signed [16:0]        sc;
	logic signed [COORD_W:0]   ox_m, oy_m, pen_m;
	logic [COORD_W-1:0]        tw_m, th_m;
	logic signed [8:0]         step;
	logic [17:0]               fh3;
	coord_t                    pen_next;

	assign sc      = $signed({1'b0, scale_q});
	assign ox_m    = (COORD_W+1)'(glyph_s1.offset_x) * (COORD_W+1)'(sc);
	assign oy_m    = (COORD_W+1)'(glyph_s1.offset_y) * (COORD_W+1)'(sc);
	assign tw_m    = COORD_W'(glyph_s1.width) * COORD_W'(scale_q);
	assign th_m    = COORD_W'(glyph_s1.height) * COORD_W'(scale_q);
	assign step    = 9'(glyph_s1.advance) + 9'(kern_s1);
	assign pen_m   = (COORD_W+1)'(step) * (COORD_W+1)'(sc);
	assign pen_next = sat_coord(SUM_W'(pen_x_q) + SUM_W'(pen_m));
	assign fh3     = 18'(font_height_q) * 18'd3;

	assign is_char  = mode_s1 == MODE_CHAR;
	assign is_end   = mode_s1 == MODE_END;
	assign draw     = is_char && gvalid_s1;
	assign capt     = capture_on_q && (draw || is_end);
	assign cur_hit  = capt && (cursor_index_q == char_idx_q);
	assign sel_act  = select_begin_q < select_end_q;
	assign sel_mark = capt && sel_act && (char_idx_q == select_begin_q);
	assign sel_emit = capt && sel_act && (char_idx_q == select_end_q);
	assign res_none = !(draw || cur_hit || sel_emit);
	assign s1_go    = valid_s1 && (res_none || bank_free);

	always_comb begin
		load.valid = s1_go ? {sel_emit, cur_hit, draw} : 3'd0;

		load.slot[0].kind     = KIND_QUAD;
		load.slot[0].screen_x = sat_coord(SUM_W'(pen_x_q) + SUM_W'(ox_m));
		load.slot[0].screen_y = sat_coord(SUM_W'(origin_y_q) + SUM_W'(oy_m));
		load.slot[0].screen_w = sat_coord($signed(SUM_W'(tw_m)));
		load.slot[0].screen_h = sat_coord($signed(SUM_W'(th_m)));
		load.slot[0].src_x    = glyph_s1.tex_left;
		load.slot[0].src_y    = glyph_s1.tex_top;
		load.slot[0].src_w    = glyph_s1.width;
		load.slot[0].src_h    = glyph_s1.height;
		load.slot[0].last     = !cur_hit && !sel_emit;

		load.slot[1].kind     = KIND_CURSOR;
		load.slot[1].screen_x = pen_x_q;
		load.slot[1].screen_y = sat_coord(SUM_W'(origin_y_q) +
			$signed(SUM_W'(font_height_q[15:3])));
		load.slot[1].screen_w = COORD_W'(2 << FRAC_BITS);
		load.slot[1].screen_h = COORD_W'(fh3[17:2]);
		load.slot[1].src_x    = 12'd0;
		load.slot[1].src_y    = 12'd0;
		load.slot[1].src_w    = 8'd0;
		load.slot[1].src_h    = 8'd0;
		load.slot[1].last     = !sel_emit;

		load.slot[2].kind     = KIND_SELECT;
		load.slot[2].screen_x = sel_left_q;
		load.slot[2].screen_y = origin_y_q;
		load.slot[2].screen_w = sat_coord(SUM_W'(pen_x_q) - SUM_W'(sel_left_q));
		load.slot[2].screen_h = COORD_W'(font_height_q);
		load.slot[2].src_x    = 12'd0;
		load.slot[2].src_y    = 12'd0;
		load.slot[2].src_w    = 8'd0;
		load.slot[2].src_h    = 8'd0;
		load.slot[2].last     = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q     <= '0;
			origin_y_q     <= '0;
			font_height_q  <= FONT_HEIGHT_RST;
			scale_q        <= SCALE_RST;
			cursor_index_q <= 16'd0;
			select_begin_q <= 16'd0;
			select_end_q   <= 16'd0;
			capture_on_q   <= 1'b0;
			pen_x_q        <= '0;
			sel_left_q     <= '0;
			char_idx_q     <= 16'd0;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_ORIGIN_X: begin
					origin_x_q <= cfg_wdata;
					pen_x_q    <= cfg_wdata;
				end
				REG_ORIGIN_Y:     origin_y_q     <= cfg_wdata;
				REG_FONT_HEIGHT:  font_height_q  <= cfg_wdata[15:0];
				REG_SCALE:        scale_q        <= cfg_wdata[15:0];
				REG_CURSOR_INDEX: cursor_index_q <= cfg_wdata[15:0];
				REG_SELECT_BEGIN: select_begin_q <= cfg_wdata[15:0];
				REG_SELECT_END:   select_end_q   <= cfg_wdata[15:0];
				REG_CAPTURE_ON:   capture_on_q   <= cfg_wdata[0];
				default: begin
				end
			endcase
		end else if (s1_go) begin
			if (is_end) begin
				pen_x_q    <= origin_x_q;
				sel_left_q <= '0;
				char_idx_q <= 16'd0;
			end else if (is_char) begin
				char_idx_q <= char_idx_q + 16'd1;
				if (draw) begin
					pen_x_q <= pen_next;
				end
				if (sel_mark) begin
					sel_left_q <= pen_x_q;
				end
			end
		end
	end

	bfgl_result_bank u_bank (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (load),
		.free    (bank_free),
		.results (results)
	);

endmodule

// ===== rtl/bfgl_result_bank.sv =====
// Output bank: holds the up to three results of one character and sends them
// in order, one beat per cycle while ready. Depends on bfgl_pkg, bfgl_result_if.
module bfgl_result_bank (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bfgl_pkg::bank_load_t  load,
	output logic                  free,
	bfgl_result_if.source         results
);
	import bfgl_pkg::*;

	logic [2:0] vld_q;
	result_t    slot_q [3];
	logic [2:0] head;
	logic [2:0] pop_mask;
	logic       pop;

	assign head = vld_q & (~vld_q + 3'd1);
	assign pop  = results.valid && results.ready;
	assign pop_mask = pop ? head : 3'd0;

	always_comb begin
		results.valid = |vld_q;
		if (head[0]) begin
			results.data = slot_q[0];
		end else if (head[1]) begin
			results.data = slot_q[1];
		end else begin
			results.data = slot_q[2];
		end
	end

	// The bank can take a new set once at most one beat is left and it leaves now.
	assign free = ((vld_q & (vld_q - 3'd1)) == 3'd0) && ((vld_q == 3'd0) || results.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 3'd0;
		end else if (load.valid != 3'd0) begin
			vld_q <= load.valid;
		end else begin
			vld_q <= vld_q & ~pop_mask;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (load.valid[i]) begin
				slot_q[i] <= load.slot[i];
			end
		end
	end

endmodule
